// ----- hw/rtl/gsc_pkg.sv -----
package gsc_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int WIN         = 7;
    localparam int HALF        = 3;
    localparam int STORE_ROWS  = 6;
    localparam int SLOT_W      = 3;
    localparam int LEVEL_W     = 16;
    localparam int COEF_W      = 17;
    localparam int TAP_PROD_W  = LEVEL_W + COEF_W;
    localparam int ROW_SUM_W   = TAP_PROD_W + 2;
    localparam int ROW_PROD_W  = ROW_SUM_W + COEF_W;
    localparam int ACC_W       = ROW_PROD_W + 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [COL_W:0] width;
        logic [ROW_W:0] height;
    } t_geom;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [1:0]       base;
        logic             last;
        logic             done;
    } t_job;

    typedef logic [WIN-1:0][WIN-1:0][LEVEL_W-1:0] t_win;
    typedef logic [HALF:0][COEF_W-1:0] t_coef;

endpackage

// ----- hw/rtl/gaussian_smooth_clamp_2d_unit.sv -----
// An item waits for the engine and its queue to drain; line-store reads then shift one
// column (sample) or the whole 7x7 window (drain tick) in. Each result pixel is summed in
// the single shared multiply-accumulate engine, row by row: taps, row add, row multiply,
// row accumulate. A new item is taken only after the previous one's results are queued.
// Reset is synchronous, active low: counters, config and handshakes return to defaults;
// the line store is not cleared and needs no clearing pass.
module gaussian_smooth_clamp_2d_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [gsc_pkg::COEF_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [gsc_pkg::LEVEL_W-1:0]   i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gsc_pkg::LEVEL_W-1:0]   o_level,
    output logic [gsc_pkg::ROW_W-1:0]     o_out_row,
    output logic [gsc_pkg::COL_W-1:0]     o_out_column,
    output logic                          o_last_of_run,
    output logic                          o_frame_done
);
    import gsc_pkg::*;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_MIN_LEVEL, REG_MAX_LEVEL,
        REG_COEF_CENTER, REG_COEF_OFF_ONE, REG_COEF_OFF_TWO, REG_COEF_OFF_THREE
    } t_reg;

    logic [10:0]          r_cfg_w;
    logic [12:0]          r_cfg_h;
    logic [LEVEL_W-1:0]   r_min;
    logic [LEVEL_W-1:0]   r_max;
    logic [COEF_W-1:0]    r_c0;
    logic [LEVEL_W-1:0]   r_c1;
    logic [LEVEL_W-1:0]   r_c2;
    logic [LEVEL_W-1:0]   r_c3;

    t_geom  geom;
    t_coef  coef;
    t_win   win;
    t_job   f_job;
    t_job   e_job;
    logic   f_q_valid;
    logic   f_q_ready;
    logic   e_q_valid;
    logic   e_q_ready;
    logic   e_idle;
    logic   back_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 11'd256;
            r_cfg_h <= 13'd256;
            r_min   <= '0;
            r_max   <= '1;
            r_c0    <= COEF_W'(65536);
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_FRAME_WIDTH:    r_cfg_w <= i_cfg_data[10:0];
                REG_FRAME_HEIGHT:   r_cfg_h <= i_cfg_data[12:0];
                REG_MIN_LEVEL:      r_min   <= i_cfg_data[LEVEL_W-1:0];
                REG_MAX_LEVEL:      r_max   <= i_cfg_data[LEVEL_W-1:0];
                REG_COEF_CENTER:    r_c0    <= i_cfg_data;
                REG_COEF_OFF_ONE:   r_c1    <= i_cfg_data[LEVEL_W-1:0];
                REG_COEF_OFF_TWO:   r_c2    <= i_cfg_data[LEVEL_W-1:0];
                REG_COEF_OFF_THREE: r_c3    <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign geom.width  = (r_cfg_w == '0) ? (COL_W+1)'(1)
                       : (r_cfg_w > 11'(MAX_WIDTH)) ? (COL_W+1)'(MAX_WIDTH)
                       : (COL_W+1)'(r_cfg_w);
    assign geom.height = (r_cfg_h == '0) ? 13'd1
                       : (r_cfg_h > 13'd4096) ? 13'd4096 : r_cfg_h;
    assign coef = {{1'b0, r_c3}, {1'b0, r_c2}, {1'b0, r_c1}, r_c0};
    assign back_idle = e_idle && !e_q_valid;

    gsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_sample    (i_sample),
        .i_geom      (geom),
        .i_back_idle (back_idle),
        .o_q_valid   (f_q_valid),
        .i_q_ready   (f_q_ready),
        .o_q_job     (f_job),
        .o_win       (win)
    );

    gsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_q_valid),
        .o_ready (f_q_ready),
        .i_job   (f_job),
        .o_valid (e_q_valid),
        .i_ready (e_q_ready),
        .o_job   (e_job)
    );

    gsc_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (e_q_valid),
        .o_q_ready     (e_q_ready),
        .i_q_job       (e_job),
        .i_win         (win),
        .i_geom        (geom),
        .i_coef        (coef),
        .i_min_level   (r_min),
        .i_max_level   (r_max),
        .o_idle        (e_idle),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_level       (o_level),
        .o_out_row     (o_out_row),
        .o_out_column  (o_out_column),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

endmodule

// ----- hw/rtl/gsc_queue.sv -----
module gsc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gsc_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output gsc_pkg::t_job o_job
);
    import gsc_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/gsc_front.sv -----
module gsc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [gsc_pkg::LEVEL_W-1:0]   i_sample,
    input  gsc_pkg::t_geom                i_geom,
    input  logic                          i_back_idle,
    output logic                          o_q_valid,
    input  logic                          i_q_ready,
    output gsc_pkg::t_job                 o_q_job,
    output gsc_pkg::t_win                 o_win
);
    import gsc_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_WAIT, F_LOAD, F_PUSH, F_FINISH} t_fstate;

    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                   input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W+1)'(STORE_ROWS)) begin
            s = s - (SLOT_W+1)'(STORE_ROWS);
        end
        return s[SLOT_W-1:0];
    endfunction

    t_fstate             r_state;
    logic [ROW_W:0]      r_in_row;
    logic [COL_W-1:0]    r_in_col;
    logic [SLOT_W-1:0]   r_in_slot;
    logic [ROW_W:0]      r_emit_row;
    logic [COL_W-1:0]    r_emit_col;
    logic [SLOT_W-1:0]   r_emit_slot;
    logic                r_drain;
    logic [LEVEL_W-1:0]  r_sample;
    logic [COL_W-1:0]    r_ic;
    logic                r_last;
    logic [SLOT_W-1:0]   r_b;
    logic [2:0]          r_k;
    logic [ROW_W-1:0]    r_r;
    logic [COL_W-1:0]    r_c;
    logic [COL_W-1:0]    r_hi;
    logic [1:0]          r_cnt;
    logic                r_done;
    t_win                r_win;

    logic [LEVEL_W-1:0]  r_store [STORE_ROWS][MAX_WIDTH];
    logic [LEVEL_W-1:0]  r_rd [STORE_ROWS];

    logic [COL_W-1:0]    w_m1;
    logic [COL_W-1:0]    ic_clamp;
    logic [COL_W-1:0]    rd_addr;
    logic                store_we;
    logic [COL_W-1:0]    col_diff;
    logic                job_last;
    logic                job_done;
    logic [SLOT_W-1:0]   row_slot;
    logic                wrap;
    logic                col_over;
    logic                ic_ge;
    logic                shift_end;

    assign w_m1     = COL_W'(i_geom.width - 1'b1);
    assign ic_clamp = (r_in_col > w_m1) ? w_m1 : r_in_col;
    assign rd_addr  = r_drain ? (r_c + COL_W'(r_k) - COL_W'(HALF)) : r_ic;
    assign store_we = (r_state == F_LOAD) && !r_drain && (r_k == 3'd0);
    assign col_diff = r_c + COL_W'(HALF) - r_ic;
    assign job_last = (r_c == r_hi) || (r_cnt == 2'd3);
    assign job_done = ({1'b0, r_r} == i_geom.height - 1'b1) && (r_c == w_m1);
    assign row_slot = r_drain ? r_emit_slot : slot_add(r_in_slot, SLOT_W'(HALF));
    assign wrap     = ({1'b0, r_c} + 1'b1) >= i_geom.width;
    assign col_over = {1'b0, r_emit_col} >= i_geom.width;
    assign ic_ge    = r_ic >= COL_W'(HALF);
    assign shift_end = r_drain ? (r_k == 3'd7) : (r_k == 3'd1);

    assign o_ready     = (r_state == F_IDLE);
    assign o_q_valid   = (r_state == F_PUSH);
    assign o_q_job.row  = r_r;
    assign o_q_job.col  = r_c;
    assign o_q_job.base = r_drain ? 2'd0 : col_diff[1:0];
    assign o_q_job.last = job_last;
    assign o_q_job.done = job_done;
    assign o_win       = r_win;

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_in_slot][r_ic] <= r_sample;
        end
        for (int b = 0; b < STORE_ROWS; b++) begin
            r_rd[b] <= r_store[b][rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_slot   <= '0;
            r_emit_row  <= '0;
            r_emit_col  <= '0;
            r_emit_slot <= '0;
            r_drain     <= 1'b0;
            r_done      <= 1'b0;
            r_k         <= '0;
            r_cnt       <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_done <= 1'b0;
                        r_k    <= '0;
                        if (!i_kind) begin
                            if (r_in_row < i_geom.height) begin
                                r_drain  <= 1'b0;
                                r_sample <= i_sample;
                                r_ic     <= ic_clamp;
                                r_last   <= (ic_clamp == w_m1);
                                r_b      <= r_in_slot;
                                r_state  <= F_WAIT;
                            end
                        end else if (r_in_row >= i_geom.height) begin
                            if ((col_over ? r_emit_row + 1'b1 : r_emit_row)
                                    >= i_geom.height) begin
                                r_in_row    <= '0;
                                r_in_col    <= '0;
                                r_in_slot   <= '0;
                                r_emit_row  <= '0;
                                r_emit_col  <= '0;
                                r_emit_slot <= '0;
                            end else begin
                                r_drain <= 1'b1;
                                if (col_over) begin
                                    r_emit_row  <= r_emit_row + 1'b1;
                                    r_emit_col  <= '0;
                                    r_emit_slot <= slot_add(r_emit_slot, SLOT_W'(1));
                                    r_r         <= ROW_W'(r_emit_row + 1'b1);
                                    r_c         <= '0;
                                    r_hi        <= '0;
                                    r_b <= slot_add(slot_add(r_emit_slot, SLOT_W'(1)),
                                                    SLOT_W'(HALF));
                                end else begin
                                    r_r  <= ROW_W'(r_emit_row);
                                    r_c  <= r_emit_col;
                                    r_hi <= r_emit_col;
                                    r_b  <= slot_add(r_emit_slot, SLOT_W'(HALF));
                                end
                                r_cnt   <= '0;
                                r_state <= F_WAIT;
                            end
                        end
                    end
                end
                F_WAIT: begin
                    if (i_back_idle) begin
                        r_state <= F_LOAD;
                    end
                end
                F_LOAD: begin
                    r_k <= r_k + 1'b1;
                    if (r_k != 3'd0) begin
                        for (int i = 0; i < WIN; i++) begin
                            for (int j = 0; j < WIN - 1; j++) begin
                                r_win[i][j] <= r_win[i][j+1];
                            end
                            if (i == WIN - 1 && !r_drain) begin
                                r_win[i][WIN-1] <= r_sample;
                            end else begin
                                r_win[i][WIN-1] <= r_rd[slot_add(r_b, SLOT_W'(i))];
                            end
                        end
                    end
                    if (shift_end) begin
                        if (r_drain) begin
                            r_state <= F_PUSH;
                        end else if ((r_in_row >= (ROW_W+1)'(HALF)) && (ic_ge || r_last)) begin
                            r_r     <= ROW_W'(r_in_row - (ROW_W+1)'(HALF));
                            r_c     <= ic_ge ? r_ic - COL_W'(HALF) : '0;
                            r_hi    <= r_last ? w_m1 : r_ic - COL_W'(HALF);
                            r_cnt   <= '0;
                            r_state <= F_PUSH;
                        end else begin
                            r_state <= F_FINISH;
                        end
                    end
                end
                F_PUSH: begin
                    if (i_q_ready) begin
                        if (job_done) begin
                            r_done <= 1'b1;
                        end
                        if (wrap) begin
                            r_emit_row  <= {1'b0, r_r} + 1'b1;
                            r_emit_col  <= '0;
                            r_emit_slot <= slot_add(row_slot, SLOT_W'(1));
                        end else begin
                            r_emit_row  <= {1'b0, r_r};
                            r_emit_col  <= r_c + 1'b1;
                            r_emit_slot <= row_slot;
                        end
                        if (job_last) begin
                            r_state <= F_FINISH;
                        end else begin
                            r_c   <= r_c + 1'b1;
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                F_FINISH: begin
                    if (r_done) begin
                        r_in_row    <= '0;
                        r_in_col    <= '0;
                        r_in_slot   <= '0;
                        r_emit_row  <= '0;
                        r_emit_col  <= '0;
                        r_emit_slot <= '0;
                    end else if (!r_drain) begin
                        if (r_last) begin
                            r_in_col  <= '0;
                            r_in_row  <= r_in_row + 1'b1;
                            r_in_slot <= slot_add(r_in_slot, SLOT_W'(1));
                        end else begin
                            r_in_col <= r_ic + 1'b1;
                        end
                    end
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_LOAD) |-> i_back_idle)
        else $error("window reload while engine busy");

    a_last_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_valid && i_q_ready && o_q_job.last) |=> (r_state == F_FINISH))
        else $error("last job did not close the transaction");

endmodule

// ----- hw/rtl/gsc_engine.sv -----
module gsc_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  gsc_pkg::t_job                 i_q_job,
    input  gsc_pkg::t_win                 i_win,
    input  gsc_pkg::t_geom                i_geom,
    input  gsc_pkg::t_coef                i_coef,
    input  logic [gsc_pkg::LEVEL_W-1:0]   i_min_level,
    input  logic [gsc_pkg::LEVEL_W-1:0]   i_max_level,
    output logic                          o_idle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gsc_pkg::LEVEL_W-1:0]   o_level,
    output logic [gsc_pkg::ROW_W-1:0]     o_out_row,
    output logic [gsc_pkg::COL_W-1:0]     o_out_column,
    output logic                          o_last_of_run,
    output logic                          o_frame_done
);
    import gsc_pkg::*;

    typedef enum logic [2:0] {E_IDLE, E_TAP, E_ROWADD, E_ROWMUL, E_ROWACC, E_OUT} t_estate;

    function automatic logic [1:0] tap_off(input logic [2:0] k);
        return (k >= 3'(HALF)) ? 2'(k - 3'(HALF)) : 2'(3'(HALF) - k);
    endfunction

    t_estate                r_state;
    t_job                   r_job;
    logic [2:0]             r_ky;
    logic [2:0]             r_kx;
    logic [TAP_PROD_W-1:0]  r_prod;
    logic [ROW_SUM_W-1:0]   r_rowsum;
    logic [ROW_PROD_W-1:0]  r_prody;
    logic [ACC_W-1:0]       r_acc;
    logic                   r_valid;
    logic [LEVEL_W-1:0]     r_level;
    logic [ROW_W-1:0]       r_out_row;
    logic [COL_W-1:0]       r_out_col;
    logic                   r_out_last;
    logic                   r_out_done;

    logic [ROW_W:0]         t_row;
    logic [COL_W:0]         u_col;
    logic [3:0]             j_idx;
    logic                   row_ok;
    logic                   col_ok;
    logic [LEVEL_W-1:0]     tap;
    logic [COEF_W-1:0]      cx;
    logic [COEF_W-1:0]      cy;
    logic [ACC_W:0]         rnd;
    logic [ACC_W-32:0]      v_rnd;
    logic [LEVEL_W-1:0]     v_hi;
    logic [LEVEL_W-1:0]     v_fin;
    logic                   out_free;

    assign t_row  = {1'b0, r_job.row} + (ROW_W+1)'(r_ky);
    assign u_col  = {1'b0, r_job.col} + (COL_W+1)'(r_kx);
    assign j_idx  = {2'b00, r_job.base} + {1'b0, r_kx};
    assign row_ok = (t_row >= (ROW_W+1)'(HALF))
                 && ((t_row - (ROW_W+1)'(HALF)) < i_geom.height);
    assign col_ok = (u_col >= (COL_W+1)'(HALF))
                 && ((u_col - (COL_W+1)'(HALF)) < i_geom.width)
                 && (j_idx <= 4'(WIN - 1));
    assign tap    = col_ok ? i_win[r_ky][j_idx[2:0]] : '0;
    assign cx     = i_coef[tap_off(r_kx)];
    assign cy     = i_coef[tap_off(r_ky)];

    assign rnd   = {1'b0, r_acc} + (ACC_W+1)'(64'h8000_0000);
    assign v_rnd = rnd[ACC_W:32];
    assign v_hi  = (v_rnd > (ACC_W-31)'(i_max_level)) ? i_max_level : v_rnd[LEVEL_W-1:0];
    assign v_fin = (v_hi < i_min_level) ? i_min_level : v_hi;

    assign out_free     = !r_valid || i_ready;
    assign o_q_ready    = (r_state == E_IDLE);
    assign o_idle       = (r_state == E_IDLE);
    assign o_valid      = r_valid;
    assign o_level      = r_level;
    assign o_out_row    = r_out_row;
    assign o_out_column = r_out_col;
    assign o_last_of_run = r_out_last;
    assign o_frame_done = r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_valid <= 1'b0;
            r_ky    <= '0;
            r_kx    <= '0;
        end else begin
            if (r_valid && i_ready && (r_state != E_OUT)) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                E_IDLE: begin
                    if (i_q_valid) begin
                        r_job    <= i_q_job;
                        r_ky     <= '0;
                        r_kx     <= '0;
                        r_prod   <= '0;
                        r_rowsum <= '0;
                        r_acc    <= '0;
                        r_state  <= E_TAP;
                    end
                end
                E_TAP: begin
                    r_prod   <= TAP_PROD_W'(tap) * TAP_PROD_W'(cx);
                    r_rowsum <= r_rowsum + ROW_SUM_W'(r_prod);
                    r_kx     <= r_kx + 1'b1;
                    if (r_kx == 3'(WIN - 1)) begin
                        r_state <= E_ROWADD;
                    end
                end
                E_ROWADD: begin
                    r_rowsum <= r_rowsum + ROW_SUM_W'(r_prod);
                    r_state  <= E_ROWMUL;
                end
                E_ROWMUL: begin
                    r_prody <= row_ok ? ROW_PROD_W'(r_rowsum) * ROW_PROD_W'(cy) : '0;
                    r_state <= E_ROWACC;
                end
                E_ROWACC: begin
                    r_acc    <= r_acc + ACC_W'(r_prody);
                    r_rowsum <= '0;
                    r_prod   <= '0;
                    r_kx     <= '0;
                    if (r_ky == 3'(WIN - 1)) begin
                        r_state <= E_OUT;
                    end else begin
                        r_ky    <= r_ky + 1'b1;
                        r_state <= E_TAP;
                    end
                end
                E_OUT: begin
                    if (out_free) begin
                        r_valid    <= 1'b1;
                        r_level    <= v_fin;
                        r_out_row  <= r_job.row;
                        r_out_col  <= r_job.col;
                        r_out_last <= r_job.last;
                        r_out_done <= r_job.done;
                        r_state    <= E_IDLE;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                end
            endcase
        end
    end

    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == E_OUT))
        else $error("result appeared without a finished sum");

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && o_q_ready) |=> ((r_state == E_TAP) && (r_ky == 3'd0)))
        else $error("job pop did not start a sum");

endmodule
